@@ hw/rtl/asmkl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmkl_pkg - shared types and constants of the assembly keyword lexer
// Mnemonic table, status codes, token field types and special byte values.
// ----------------------------------------------------------------------------
package asmkl_pkg;

    localparam int NUM_KEYS     = 23;
    localparam int KEY_LEN_MAX  = 6;
    localparam int KEY_LEN_BITS = 3;
    localparam int CODE_BITS    = 5;
    localparam int FIELD_BITS   = 16;

    typedef logic [7:0]              byte_t;
    typedef logic [CODE_BITS-1:0]    code_t;
    typedef logic [FIELD_BITS-1:0]   field_t;
    typedef logic [KEY_LEN_BITS-1:0] key_len_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_UNKNOWN  = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } status_t;

    localparam code_t CODE_NONE    = '0;
    localparam byte_t BYTE_END     = 8'd0;
    localparam byte_t BYTE_NEWLINE = 8'd10;

    // Mnemonics right-aligned, first letter in the most significant used byte
    localparam logic [8*KEY_LEN_MAX-1:0] KEY_TEXT [NUM_KEYS] = '{
        "nop", "push", "pop", "dup", "indup", "swap", "inswap", "add", "sub",
        "mul", "div", "mod", "cmpe", "cmpne", "cmpg", "cmpl", "cmpge", "cmple",
        "jmp", "zjmp", "nzjmp", "print", "halt"
    };

    localparam key_len_t KEY_LEN [NUM_KEYS] = '{
        3'd3, 3'd4, 3'd3, 3'd3, 3'd5, 3'd4, 3'd6, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd4, 3'd5, 3'd4, 3'd4, 3'd5, 3'd5,
        3'd3, 3'd4, 3'd5, 3'd5, 3'd4
    };

    function automatic byte_t key_char(input int k, input int i);
        int len;
        byte_t c;
        len = int'(KEY_LEN[k]);
        c   = '0;
        if (i < len)
        begin
            c = KEY_TEXT[k][8*(len-1-i) +: 8];
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/asmkl_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmkl_if - channel interfaces of the assembly keyword lexer
// Text byte channel and token channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface asmkl_byte_if;
    logic              valid;
    logic              ready;
    asmkl_pkg::byte_t  text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface asmkl_token_if;
    logic                valid;
    logic                ready;
    asmkl_pkg::code_t    token_code;
    asmkl_pkg::field_t   token_line;
    asmkl_pkg::field_t   token_column;
    asmkl_pkg::status_t  status;

    modport source (output valid, output token_code, output token_line,
                    output token_column, output status, input ready);
    modport sink   (input valid, input token_code, input token_line,
                    input token_column, input status, output ready);
endinterface

@@ hw/rtl/assembly_keyword_lexer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assembly_keyword_lexer_core - keyword lexer for stack-machine assembly
// Collects letter runs from a byte stream and emits mnemonic tokens.
// ----------------------------------------------------------------------------
// Takes one text byte every cycle. A token appears on the output register in
// the cycle after the byte that ends its word; text.ready falls only while a
// token sits in that register and token.ready is low. Matching against all
// mnemonics runs in parallel in the cycle the ending byte is taken. Byte 0
// flushes a pending word and restarts line and column at 1; counts saturate
// at 2**POS_BITS-1, and the token fields carry their low 16 bits.
module assembly_keyword_lexer_core #(
    parameter int MAX_WORD = 9,
    parameter int POS_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    asmkl_byte_if.sink           text,
    asmkl_token_if.source        token
);
    import asmkl_pkg::*;

    localparam int LEN_BITS = $clog2(MAX_WORD + 1);
    localparam int IDX_BITS = $clog2(MAX_WORD);

    typedef logic [POS_BITS-1:0] pos_t;

    byte_t                letters_reg [MAX_WORD];
    logic [LEN_BITS-1:0]  word_len_reg;
    logic                 too_long_reg;
    pos_t                 line_reg;
    pos_t                 column_reg;
    pos_t                 start_line_reg;
    pos_t                 start_column_reg;

    logic                 out_valid_reg;
    code_t                out_code_reg;
    field_t               out_line_reg;
    field_t               out_column_reg;
    status_t              out_status_reg;

    logic                 accept;
    logic                 is_letter;
    logic                 pending;
    logic                 emit;
    code_t                match_code;
    code_t                out_code_next;
    status_t              out_status_next;
    logic [POS_BITS+FIELD_BITS-1:0] line_ext;
    logic [POS_BITS+FIELD_BITS-1:0] column_ext;

    function automatic pos_t sat_inc(input pos_t v);
        return (v == '1) ? v : v + pos_t'(1);
    endfunction

    asmkl_match #(
        .MAX_WORD (MAX_WORD)
    ) u_match (
        .letters (letters_reg),
        .length  (word_len_reg),
        .code    (match_code)
    );

    assign text.ready = !out_valid_reg || token.ready;
    assign accept     = text.valid && text.ready;
    assign is_letter  = (text.text_byte inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    assign pending    = (word_len_reg != '0) || too_long_reg;
    assign emit       = accept && !is_letter && pending;

    assign line_ext   = {{FIELD_BITS{1'b0}}, start_line_reg};
    assign column_ext = {{FIELD_BITS{1'b0}}, start_column_reg};

    always_comb
    begin
        if (too_long_reg)
        begin
            out_code_next   = CODE_NONE;
            out_status_next = STATUS_TOO_LONG;
        end
        else
        begin
            out_code_next   = match_code;
            out_status_next = (match_code != CODE_NONE) ? STATUS_OK : STATUS_UNKNOWN;
        end
    end

    // word and position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_len_reg     <= '0;
            too_long_reg     <= 1'b0;
            line_reg         <= pos_t'(1);
            column_reg       <= pos_t'(1);
            start_line_reg   <= pos_t'(1);
            start_column_reg <= pos_t'(1);
        end
        else if (accept)
        begin
            if (is_letter)
            begin
                if (!pending)
                begin
                    start_line_reg   <= line_reg;
                    start_column_reg <= column_reg;
                end
                if (word_len_reg < LEN_BITS'(MAX_WORD))
                begin
                    word_len_reg <= word_len_reg + LEN_BITS'(1);
                end
                else
                begin
                    too_long_reg <= 1'b1;
                end
                column_reg <= sat_inc(column_reg);
            end
            else
            begin
                word_len_reg <= '0;
                too_long_reg <= 1'b0;
                case (text.text_byte)
                    BYTE_END:
                    begin
                        line_reg   <= pos_t'(1);
                        column_reg <= pos_t'(1);
                    end
                    BYTE_NEWLINE:
                    begin
                        line_reg   <= sat_inc(line_reg);
                        column_reg <= pos_t'(1);
                    end
                    default:
                    begin
                        column_reg <= sat_inc(column_reg);
                    end
                endcase
            end
        end
    end

    // letter store, written at the current length
    always_ff @(posedge clk)
    begin
        if (accept && is_letter && word_len_reg < LEN_BITS'(MAX_WORD))
        begin
            letters_reg[word_len_reg[IDX_BITS-1:0]] <= text.text_byte;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (token.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_code_reg   <= out_code_next;
            out_line_reg   <= line_ext[FIELD_BITS-1:0];
            out_column_reg <= column_ext[FIELD_BITS-1:0];
            out_status_reg <= out_status_next;
        end
    end

    assign token.valid        = out_valid_reg;
    assign token.token_code   = out_code_reg;
    assign token.token_line   = out_line_reg;
    assign token.token_column = out_column_reg;
    assign token.status       = out_status_reg;

endmodule

@@ hw/rtl/asmkl_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmkl_match - mnemonic matcher
// Compares the held word against every mnemonic in parallel.
// ----------------------------------------------------------------------------
module asmkl_match #(
    parameter int MAX_WORD = 9
) (
    input  asmkl_pkg::byte_t                     letters [MAX_WORD],
    input  logic [$clog2(MAX_WORD+1)-1:0]        length,
    output asmkl_pkg::code_t                     code
);
    import asmkl_pkg::*;

    localparam int LEN_BITS = $clog2(MAX_WORD + 1);

    always_comb
    begin
        logic same;
        code = CODE_NONE;
        for (int k = NUM_KEYS - 1; k >= 0; k--)
        begin
            same = (length == LEN_BITS'(KEY_LEN[k]));
            for (int i = 0; i < KEY_LEN_MAX; i++)
            begin
                if (i < int'(KEY_LEN[k]) && letters[i] != key_char(k, i))
                begin
                    same = 1'b0;
                end
            end
            if (same)
            begin
                code = CODE_BITS'(k + 1);
            end
        end
    end

endmodule
